[hdl/thc_pkg.sv]
// Shared types, constants and tables for the tilt-compensated heading pipeline.
package thc_pkg;

   // Number of CORDIC micro-rotations (one pipeline stage each), 8 to 24
   localparam int CORDIC_ITERATIONS = 16;

   // Field and datapath widths
   localparam int CDEG_W  = 16;   // angles in hundredths of a degree
   localparam int RAW_W   = 16;   // raw axis samples
   localparam int GAIN_W  = 11;   // Q3.8 gain scale
   localparam int CSR_W   = 16;   // widest register
   localparam int CSR_IDX_W = 2;
   localparam int PRODG_W = RAW_W + GAIN_W + 1;  // raw times gain
   localparam int AXIS_W  = 19;   // scaled axis, |a| <= 262016
   localparam int BANG_W  = 32;   // binary angle, one turn = 2^32
   localparam int TRIG_W  = 34;   // rotation CORDIC internals
   localparam int Q30_W   = 32;   // sin and cos in Q30
   localparam int MPROD_W = AXIS_W + Q30_W;  // axis times Q30 term
   localparam int XH_W    = MPROD_W + 3;      // tilt-compensated components
   localparam int VEC_W   = 56;   // vectoring CORDIC internals
   localparam int CONV_V_W = 25;  // remainder numerator in angle conversion
   localparam int CONV_Q_W = 15;  // remainder quotient
   localparam int CONV_T_W = 50;  // reciprocal product
   localparam int CONV_SHIFT = 35;
   localparam int OUT_P_W = 48;   // output scaling product

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECL = 2'd1;

   // Register reset values
   localparam logic [GAIN_W-1:0]        GAIN_RESET = 11'd256;
   localparam logic signed [CDEG_W-1:0] DECL_RESET = 16'sd0;

   // Centidegree to binary angle: 2^27 = 1125 * 119304 + 728, and
   // floor((m * 2^32 + 18000) / 36000) = m * 119304 + floor((m * 728 + 562) / 1125)
   localparam int TURN_CDEG  = 36000;
   localparam int CONV_QUOT  = 119304;
   localparam int CONV_REM   = 728;
   localparam int CONV_HALF  = 562;
   localparam int CONV_DIV   = 1125;
   localparam longint CONV_RECIP = (64'd1 << CONV_SHIFT) / CONV_DIV;

   // Output scaling: round(h * 36000 / 2^32)
   localparam longint OUT_ROUND = 64'd1 << 31;

   // CORDIC constants
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [TRIG_W-1:0] ANG_QTR  = 34'sh040000000;
   localparam logic signed [TRIG_W-1:0] ANG_NQTR = -34'sh040000000;
   localparam logic signed [TRIG_W-1:0] ANG_HALF = 34'sh080000000;
   localparam logic [BANG_W-1:0]        BANG_HALF = 32'h80000000;

   localparam logic [BANG_W-1:0] ATAN_TAB [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // Per-item data that rides alongside the angle math
   typedef struct packed {
      logic signed [AXIS_W-1:0] x;
      logic signed [AXIS_W-1:0] y;
      logic signed [AXIS_W-1:0] z;
      logic [BANG_W-1:0]        decl;
   } side_type;

   // Sine and cosine of roll and pitch, Q30
   typedef struct packed {
      logic signed [Q30_W-1:0] sr;
      logic signed [Q30_W-1:0] cr;
      logic signed [Q30_W-1:0] sp;
      logic signed [Q30_W-1:0] cp;
   } trig_type;

   // Tilt-compensated field components and declination
   typedef struct packed {
      logic signed [XH_W-1:0] xh;
      logic signed [XH_W-1:0] yh;
      logic [BANG_W-1:0]      decl;
   } vec_type;

endpackage

[hdl/thc_front.sv]
// Front end: axis gain scaling and centidegree to binary angle conversion.
module thc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [thc_pkg::RAW_W-1:0]    in_x,
   input  logic signed [thc_pkg::RAW_W-1:0]    in_y,
   input  logic signed [thc_pkg::RAW_W-1:0]    in_z,
   input  logic signed [thc_pkg::CDEG_W-1:0]   in_roll,
   input  logic signed [thc_pkg::CDEG_W-1:0]   in_pitch,
   input  logic signed [thc_pkg::CDEG_W-1:0]   decl,
   input  logic [thc_pkg::GAIN_W-1:0]          gain,
   output logic                                out_valid,
   output thc_pkg::side_type                   out_side,
   output logic [1:0][thc_pkg::BANG_W-1:0]     out_ang
);
   import thc_pkg::*;

   localparam int LANE_ROLL  = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_DECL  = 2;

   logic [3:0] vld_ff;

   // stage 1: raw times gain, angle reduced into one turn
   logic signed [PRODG_W-1:0] prod_in [3];
   logic signed [PRODG_W-1:0] prod_ff [3];
   logic [CDEG_W-1:0]         m_in [3];
   logic [CDEG_W-1:0]         m_ff [3];
   logic signed [CDEG_W-1:0]  ang_raw [3];

   // stage 2: truncated axes, split conversion
   logic signed [AXIS_W-1:0]  axis_in [3];
   logic signed [AXIS_W-1:0]  axis_ff [3];
   logic signed [AXIS_W-1:0]  axis2_ff [3];
   logic signed [AXIS_W-1:0]  axis3_ff [3];
   logic [CONV_V_W-1:0]       v_in [3];
   logic [CONV_V_W-1:0]       v_ff [3];
   logic [CONV_V_W-1:0]       v2_ff [3];
   logic [BANG_W-1:0]         mq_in [3];
   logic [BANG_W-1:0]         mq_ff [3];
   logic [BANG_W-1:0]         mq2_ff [3];

   // stage 3: reciprocal estimate of the quotient
   logic [CONV_T_W-1:0]       t_in [3];
   logic [CONV_Q_W-1:0]       q0_ff [3];

   // stage 4: correct the estimate, assemble the binary angle
   logic [CONV_V_W-1:0]       rem_in [3];
   logic [CONV_Q_W-1:0]       q_in [3];
   logic [BANG_W-1:0]         bin_in [3];
   logic [BANG_W-1:0]         bin_ff [3];

   // scale axes and fold angles
   always_comb begin
      logic signed [CDEG_W:0] ext;
      ang_raw[LANE_ROLL]  = in_roll;
      ang_raw[LANE_PITCH] = in_pitch;
      ang_raw[LANE_DECL]  = decl;
      prod_in[0] = in_x * signed'({1'b0, gain});
      prod_in[1] = in_y * signed'({1'b0, gain});
      prod_in[2] = in_z * signed'({1'b0, gain});
      for (int l = 0; l < 3; l++) begin
         ext = (CDEG_W + 1)'(ang_raw[l]);
         if (ang_raw[l] < 0) begin
            ext = ext + (CDEG_W + 1)'(TURN_CDEG);
         end
         m_in[l] = ext[CDEG_W-1:0];
      end
   end

   // truncate toward zero, split the conversion into quotient and remainder parts
   always_comb begin
      logic [PRODG_W-1:0] mag;
      logic [PRODG_W-1:0] sh;
      for (int l = 0; l < 3; l++) begin
         mag = prod_ff[l][PRODG_W-1] ? PRODG_W'(-prod_ff[l]) : PRODG_W'(prod_ff[l]);
         sh  = mag >> 8;
         axis_in[l] = prod_ff[l][PRODG_W-1] ? -AXIS_W'(sh) : AXIS_W'(sh);
         v_in[l]  = CONV_V_W'(m_ff[l]) * CONV_V_W'(CONV_REM) + CONV_V_W'(CONV_HALF);
         mq_in[l] = BANG_W'(m_ff[l]) * BANG_W'(CONV_QUOT);
      end
   end

   // estimate quotient, low by at most one
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         t_in[l] = CONV_T_W'(v_ff[l]) * CONV_T_W'(CONV_RECIP);
      end
   end

   // correct by one compare and add the parts
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         rem_in[l] = v2_ff[l] - CONV_V_W'(q0_ff[l]) * CONV_V_W'(CONV_DIV);
         q_in[l]   = q0_ff[l];
         if (rem_in[l] >= CONV_V_W'(CONV_DIV)) begin
            q_in[l] = q0_ff[l] + 1'b1;
         end
         bin_in[l] = mq2_ff[l] + BANG_W'(q_in[l]);
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            prod_ff[l]  <= prod_in[l];
            m_ff[l]     <= m_in[l];
            axis_ff[l]  <= axis_in[l];
            v_ff[l]     <= v_in[l];
            mq_ff[l]    <= mq_in[l];
            axis2_ff[l] <= axis_ff[l];
            v2_ff[l]    <= v_ff[l];
            mq2_ff[l]   <= mq_ff[l];
            q0_ff[l]    <= t_in[l][CONV_SHIFT +: CONV_Q_W];
            axis3_ff[l] <= axis2_ff[l];
            bin_ff[l]   <= bin_in[l];
         end
      end
   end

   assign out_valid      = vld_ff[3];
   assign out_side.x     = axis3_ff[0];
   assign out_side.y     = axis3_ff[1];
   assign out_side.z     = axis3_ff[2];
   assign out_side.decl  = bin_ff[LANE_DECL];
   assign out_ang[0]     = bin_ff[LANE_ROLL];
   assign out_ang[1]     = bin_ff[LANE_PITCH];

endmodule

[hdl/thc_sincos.sv]
// Pipelined rotation CORDIC: sine and cosine of roll and pitch, one stage per iteration.
module thc_sincos (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  thc_pkg::side_type                in_side,
   input  logic [1:0][thc_pkg::BANG_W-1:0]  in_ang,
   output logic                             out_valid,
   output thc_pkg::side_type                out_side,
   output thc_pkg::trig_type                out_trig
);
   import thc_pkg::*;

   localparam int N = CORDIC_ITERATIONS;

   logic [N+1:0]             vld_ff;
   side_type                 side_ff [N+2];
   logic signed [TRIG_W-1:0] x_ff [N+1][2];
   logic signed [TRIG_W-1:0] y_ff [N+1][2];
   logic signed [TRIG_W-1:0] z_ff [N+1][2];
   logic [1:0]               neg_ff [N+1];
   logic signed [TRIG_W-1:0] z0_in [2];
   logic [1:0]               neg0_in;
   logic signed [TRIG_W-1:0] x_in [N][2];
   logic signed [TRIG_W-1:0] y_in [N][2];
   logic signed [TRIG_W-1:0] z_in [N][2];
   logic signed [TRIG_W-1:0] c_in [2];
   logic signed [TRIG_W-1:0] s_in [2];
   trig_type                 trig_ff;

   // fold the angle into the right half plane
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         z0_in[l]   = TRIG_W'(signed'(in_ang[l]));
         neg0_in[l] = 1'b0;
         if (z0_in[l] > ANG_QTR) begin
            z0_in[l]   = z0_in[l] - ANG_HALF;
            neg0_in[l] = 1'b1;
         end else if (z0_in[l] < ANG_NQTR) begin
            z0_in[l]   = z0_in[l] + ANG_HALF;
            neg0_in[l] = 1'b1;
         end
      end
   end

   // micro-rotations, one per stage
   always_comb begin
      for (int k = 0; k < N; k++) begin
         for (int l = 0; l < 2; l++) begin
            if (z_ff[k][l] >= 0) begin
               x_in[k][l] = x_ff[k][l] - (y_ff[k][l] >>> k);
               y_in[k][l] = y_ff[k][l] + (x_ff[k][l] >>> k);
               z_in[k][l] = z_ff[k][l] - signed'(TRIG_W'(ATAN_TAB[k]));
            end else begin
               x_in[k][l] = x_ff[k][l] + (y_ff[k][l] >>> k);
               y_in[k][l] = y_ff[k][l] - (x_ff[k][l] >>> k);
               z_in[k][l] = z_ff[k][l] + signed'(TRIG_W'(ATAN_TAB[k]));
            end
         end
      end
   end

   // undo the fold
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         c_in[l] = neg_ff[N][l] ? -x_ff[N][l] : x_ff[N][l];
         s_in[l] = neg_ff[N][l] ? -y_ff[N][l] : y_ff[N][l];
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N:0], in_valid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         neg_ff[0]  <= neg0_in;
         for (int l = 0; l < 2; l++) begin
            x_ff[0][l] <= CORDIC_GAIN_Q30;
            y_ff[0][l] <= '0;
            z_ff[0][l] <= z0_in[l];
         end
         for (int k = 0; k < N; k++) begin
            side_ff[k+1] <= side_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            for (int l = 0; l < 2; l++) begin
               x_ff[k+1][l] <= x_in[k][l];
               y_ff[k+1][l] <= y_in[k][l];
               z_ff[k+1][l] <= z_in[k][l];
            end
         end
         side_ff[N+1] <= side_ff[N];
         trig_ff.cr   <= Q30_W'(c_in[0]);
         trig_ff.sr   <= Q30_W'(s_in[0]);
         trig_ff.cp   <= Q30_W'(c_in[1]);
         trig_ff.sp   <= Q30_W'(s_in[1]);
      end
   end

   assign out_valid = vld_ff[N+1];
   assign out_side  = side_ff[N+1];
   assign out_trig  = trig_ff;

endmodule

[hdl/thc_mix.sv]
// Tilt compensation: rotate the scaled field vector into the horizontal plane.
module thc_mix (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  thc_pkg::side_type in_side,
   input  thc_pkg::trig_type in_trig,
   output logic              out_valid,
   output thc_pkg::vec_type  out_vec
);
   import thc_pkg::*;

   logic [2:0] vld_ff;

   // stage 1: products of the trig terms
   logic signed [2*Q30_W-1:0] srsp_p;
   logic signed [2*Q30_W-1:0] srcp_p;
   logic signed [Q30_W-1:0]   srsp_ff;
   logic signed [Q30_W-1:0]   srcp_ff;
   trig_type                  trig1_ff;
   side_type                  side1_ff;

   // stage 2: axis products
   logic signed [MPROD_W-1:0] pa_ff;
   logic signed [MPROD_W-1:0] pb_ff;
   logic signed [MPROD_W-1:0] pc_ff;
   logic signed [MPROD_W-1:0] pd_ff;
   logic signed [MPROD_W-1:0] pe_ff;
   logic [BANG_W-1:0]         decl2_ff;

   // stage 3: sums
   vec_type                   vec_in;
   vec_type                   vec_ff;

   // form sin r sin p and sin r cos p, floor shift by 30
   always_comb begin
      srsp_p = in_trig.sr * in_trig.sp;
      srcp_p = in_trig.sr * in_trig.cp;
   end

   // add up the components
   always_comb begin
      vec_in.xh   = XH_W'(pa_ff) + XH_W'(pb_ff);
      vec_in.yh   = XH_W'(pc_ff) + XH_W'(pd_ff) - XH_W'(pe_ff);
      vec_in.decl = decl2_ff;
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         srsp_ff  <= srsp_p[30 +: Q30_W];
         srcp_ff  <= srcp_p[30 +: Q30_W];
         trig1_ff <= in_trig;
         side1_ff <= in_side;
         pa_ff    <= side1_ff.x * trig1_ff.cp;
         pb_ff    <= side1_ff.z * trig1_ff.sp;
         pc_ff    <= side1_ff.x * srsp_ff;
         pd_ff    <= side1_ff.y * trig1_ff.cr;
         pe_ff    <= side1_ff.z * srcp_ff;
         decl2_ff <= side1_ff.decl;
         vec_ff   <= vec_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_vec   = vec_ff;

endmodule

[hdl/thc_atan.sv]
// Pipelined vectoring CORDIC for atan2, declination add and centidegree output.
module thc_atan (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  thc_pkg::vec_type                in_vec,
   output logic                            out_valid,
   output logic [thc_pkg::CDEG_W-1:0]      out_heading
);
   import thc_pkg::*;

   localparam int N = CORDIC_ITERATIONS;

   logic [N+1:0]             vld_ff;
   logic signed [VEC_W-1:0]  x_ff [N+1];
   logic signed [VEC_W-1:0]  y_ff [N+1];
   logic [BANG_W-1:0]        z_ff [N+1];
   logic [BANG_W-1:0]        decl_ff [N+1];
   logic [N:0]               zero_ff;
   logic signed [VEC_W-1:0]  x0_in;
   logic signed [VEC_W-1:0]  y0_in;
   logic [BANG_W-1:0]        z0_in;
   logic                     zero0_in;
   logic signed [VEC_W-1:0]  x_in [N];
   logic signed [VEC_W-1:0]  y_in [N];
   logic [BANG_W-1:0]        z_in [N];
   logic [BANG_W-1:0]        h_in;
   logic [OUT_P_W-1:0]       p_in;
   logic [CDEG_W-1:0]        heading_ff;

   // flip into the right half plane
   always_comb begin
      zero0_in = (in_vec.xh == '0) && (in_vec.yh == '0);
      x0_in    = VEC_W'(in_vec.xh);
      y0_in    = VEC_W'(in_vec.yh);
      z0_in    = '0;
      if (in_vec.xh < 0) begin
         x0_in = -x0_in;
         y0_in = -y0_in;
         z0_in = BANG_HALF;
      end
   end

   // drive y toward zero, one step per stage
   always_comb begin
      for (int k = 0; k < N; k++) begin
         if (y_ff[k] >= 0) begin
            x_in[k] = x_ff[k] + (y_ff[k] >>> k);
            y_in[k] = y_ff[k] - (x_ff[k] >>> k);
            z_in[k] = z_ff[k] + ATAN_TAB[k];
         end else begin
            x_in[k] = x_ff[k] - (y_ff[k] >>> k);
            y_in[k] = y_ff[k] + (x_ff[k] >>> k);
            z_in[k] = z_ff[k] - ATAN_TAB[k];
         end
      end
   end

   // add declination, scale one turn to 36000 with rounding
   always_comb begin
      h_in = zero_ff[N] ? decl_ff[N] : z_ff[N] + decl_ff[N];
      p_in = OUT_P_W'(h_in) * OUT_P_W'(TURN_CDEG) + OUT_P_W'(OUT_ROUND);
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N:0], in_valid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         decl_ff[0] <= in_vec.decl;
         zero_ff[0] <= zero0_in;
         for (int k = 0; k < N; k++) begin
            x_ff[k+1]    <= x_in[k];
            y_ff[k+1]    <= y_in[k];
            z_ff[k+1]    <= z_in[k];
            decl_ff[k+1] <= decl_ff[k];
            zero_ff[k+1] <= zero_ff[k];
         end
         heading_ff <= p_in[OUT_P_W-1 -: CDEG_W];
      end
   end

   assign out_valid   = vld_ff[N+1];
   assign out_heading = heading_ff;

endmodule

[hdl/tilt_compensated_heading.sv]
// Top level of the tilt-compensated compass heading pipeline.
//
// Request channel (req_*): one beat carries a raw X/Y/Z magnetometer sample
// and the roll and pitch of the sensor in hundredths of a degree. Response
// channel (rsp_*): one beat per request, the heading in hundredths of a
// degree (0 to 36000), in request order. Both use valid/ready.
// Registers (csr_*): index 0 is the Q3.8 axis gain, index 1 the declination;
// write them only while no request is in flight. Other indexes are ignored.
// The pipeline is four front-end stages (gain, angle conversion), the
// rotation CORDIC, three tilt-compensation stages and the vectoring CORDIC,
// one stage per iteration. Throughput is one beat per cycle while the
// receiver takes results. The whole pipeline advances together; when the
// receiver stalls with a result waiting, every stage holds and req_ready
// drops, so nothing is lost or repeated. Reset empties the pipeline at
// once and restores gain 1.0 and zero declination.
module tilt_compensated_heading (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [thc_pkg::RAW_W-1:0]   req_x_raw,
   input  logic signed [thc_pkg::RAW_W-1:0]   req_y_raw,
   input  logic signed [thc_pkg::RAW_W-1:0]   req_z_raw,
   input  logic signed [thc_pkg::CDEG_W-1:0]  req_roll_centideg,
   input  logic signed [thc_pkg::CDEG_W-1:0]  req_pitch_centideg,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [thc_pkg::CDEG_W-1:0]         rsp_heading_centideg,
   input  logic                               csr_wr_en,
   input  logic [thc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [thc_pkg::CSR_W-1:0]          csr_wdata
);
   import thc_pkg::*;

   logic [GAIN_W-1:0]        gain_ff;
   logic signed [CDEG_W-1:0] decl_ff;
   logic                     en;
   logic                     front_valid;
   side_type                 front_side;
   logic [1:0][BANG_W-1:0]   front_ang;
   logic                     trig_valid;
   side_type                 trig_side;
   trig_type                 trig;
   logic                     vec_valid;
   vec_type                  vec;

   // advance the pipeline unless a result waits on a stalled receiver
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         decl_ff <= DECL_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_GAIN: begin
               gain_ff <= csr_wdata[GAIN_W-1:0];
            end
            REG_DECL: begin
               decl_ff <= signed'(csr_wdata[CDEG_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   thc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_x      (req_x_raw),
      .in_y      (req_y_raw),
      .in_z      (req_z_raw),
      .in_roll   (req_roll_centideg),
      .in_pitch  (req_pitch_centideg),
      .decl      (decl_ff),
      .gain      (gain_ff),
      .out_valid (front_valid),
      .out_side  (front_side),
      .out_ang   (front_ang)
   );

   thc_sincos u_sincos (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_side   (front_side),
      .in_ang    (front_ang),
      .out_valid (trig_valid),
      .out_side  (trig_side),
      .out_trig  (trig)
   );

   thc_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (trig_valid),
      .in_side   (trig_side),
      .in_trig   (trig),
      .out_valid (vec_valid),
      .out_vec   (vec)
   );

   thc_atan u_atan (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (vec_valid),
      .in_vec      (vec),
      .out_valid   (rsp_valid),
      .out_heading (rsp_heading_centideg)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pipeline not empty after reset");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heading_centideg <= CDEG_W'(TURN_CDEG))
      else $error("heading beyond one turn");

   a_gain_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en && csr_index == REG_GAIN |=> gain_ff == $past(csr_wdata[GAIN_W-1:0]))
      else $error("gain register write lost");

   a_decl_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en && csr_index == REG_DECL |=> decl_ff == signed'($past(csr_wdata)))
      else $error("declination register write lost");

endmodule
